/* rtl/core/bfba_pkg.sv */
package bfba_pkg;
   localparam int unsigned ArenaBytes  = 65536;
   localparam int unsigned MaxBlocks   = 64;
   localparam int unsigned HeaderBytes = 24;
   // power of two: rounding is done with a mask
   localparam int unsigned AlignBytes  = 8;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_ZERO     = 3'd1,
      ST_NOSPACE  = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_ALREADY  = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;
endpackage

/* rtl/core/bfba_if.sv */
interface bfba_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] request_bytes;
   logic [15:0] release_address;
   modport source (output valid, operation, request_bytes, release_address, input ready);
   modport sink   (input valid, operation, request_bytes, release_address, output ready);
endinterface

interface bfba_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] payload_address;
   logic [2:0]  status;
   modport source (output valid, payload_address, status, input ready);
   modport sink   (input valid, payload_address, status, output ready);
endinterface

/* rtl/core/best_fit_block_allocator_core.sv */
// Channel   Dir  Payload                                 Handshake
// req       in   operation, request_bytes, release_addr  valid/ready
// rsp       out  payload_address, status                 valid/ready
//
// One item at a time; ready only while the sequencer is idle.
// Allocate: one read pass over the table, then on a split a shift pass that
// moves the later entries up; an append is a single write.
// Free: a search pass, then a coalesce pass over the table that moves the
// later entries down on each merge; the single table read port paces each pass.
// Reset (synchronous) clears count, heap top, the sequencer and rsp valid only.
// The result sits in an output register; a stalled rsp holds the block idle.
module best_fit_block_allocator_core
   import bfba_pkg::*;
#(
   parameter int unsigned ARENA_BYTES  = ArenaBytes,
   parameter int unsigned MAX_BLOCKS   = MaxBlocks,
   parameter int unsigned HEADER_BYTES = HeaderBytes
) (
   input logic   clock,
   input logic   reset,
   bfba_req_if.sink   req,
   bfba_rsp_if.source rsp
);
   localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [17:0] HDR = 18'(HEADER_BYTES);
   localparam logic [17:0] ALM = 18'(AlignBytes - 1);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_SRD   = 12'b000000000010, // issue read
      S_SCHK  = 12'b000000000100, // check read data
      S_PICK  = 12'b000000001000, // read best
      S_PUSE  = 12'b000000010000,
      S_SHRD  = 12'b000000100000, // insert shift: read k-1
      S_SHWR  = 12'b000001000000,
      S_INS   = 12'b000010000000,
      S_CRD   = 12'b000100000000, // coalesce read i+1
      S_CCHK  = 12'b001000000000,
      S_RMWR  = 12'b010000000000, // remove shift
      S_DONE  = 12'b100000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, best_ff, best_in, k_ff, k_in;
   logic [16:0] top_ff, top_in;
   logic        op_ff, op_in;
   logic [16:0] size_ff, size_in;     // rounded size, 65536 possible
   logic [15:0] rel_ff, rel_in, bsize_ff, bsize_in;
   logic        found_ff, found_in;
   logic [32:0] cur_ff, cur_in;       // coalesce entry i
   logic [32:0] ins_ff, ins_in;       // entry to insert
   logic [15:0] addr_ff, addr_in;
   status_type  st_ff, st_in;
   logic        rv_ff, rv_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [32:0]   wr_data, rd_data;

   bfba_table #(.DEPTH(MAX_BLOCKS), .AW(AW)) u_table (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   // table word: {free, size[15:0], start[15:0]}
   logic        e_free;
   logic [15:0] e_size, e_start;
   logic [17:0] rnd, sum;
   assign e_free  = rd_data[32];
   assign e_size  = rd_data[31:16];
   assign e_start = rd_data[15:0];
   assign rnd     = (18'(req.request_bytes) + ALM) & ~ALM;

   assign req.ready           = (state_ff == S_IDLE) && !rv_ff;
   assign rsp.valid           = rv_ff;
   assign rsp.payload_address = addr_ff;
   assign rsp.status          = st_ff;

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; best_in = best_ff;
      k_in = k_ff; top_in = top_ff; op_in = op_ff; size_in = size_ff; rel_in = rel_ff;
      bsize_in = bsize_ff; found_in = found_ff; cur_in = cur_ff; ins_in = ins_ff;
      addr_in = addr_ff; st_in = st_ff; rv_in = rv_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = AW'(idx_ff); sum = '0;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               op_in = req.operation; rel_in = req.release_address;
               size_in = rnd[16:0]; idx_in = '0; found_in = 1'b0;
               addr_in = '0; st_in = ST_OK;
               if (req.operation == OP_ALLOC && req.request_bytes == 16'd0) begin
                  st_in = ST_ZERO; state_in = S_DONE;
               end else if (req.operation == OP_FREE && req.release_address == 16'd0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SRD;
               end
            end
         end
         S_SRD: begin
            if (idx_ff == count_ff) begin
               if (op_ff == OP_FREE) begin
                  st_in = ST_NOTFOUND; state_in = S_DONE;
               end else if (found_ff) begin
                  idx_in = best_ff; state_in = S_PICK;
               end else begin
                  sum = 18'(top_ff) + HDR + 18'(size_ff);
                  if (count_ff >= CW'(MAX_BLOCKS) || sum > 18'(ARENA_BYTES)) begin
                     st_in = ST_NOSPACE; state_in = S_DONE;
                  end else begin
                     wr_en = 1'b1; wr_addr = AW'(count_ff);
                     wr_data = {1'b0, size_ff[15:0], top_ff[15:0]};
                     addr_in = 16'(18'(top_ff) + HDR);
                     top_in = sum[16:0]; count_in = count_ff + 1'b1;
                     state_in = S_DONE;
                  end
               end
            end else begin
               state_in = S_SCHK;
            end
         end
         S_SCHK: begin
            state_in = S_SRD; idx_in = idx_ff + 1'b1;
            if (op_ff == OP_FREE) begin
               if (16'(18'(e_start) + HDR) == rel_ff) begin
                  if (e_free) begin
                     st_in = ST_ALREADY; state_in = S_DONE;
                  end else begin
                     wr_en = 1'b1; wr_addr = AW'(idx_ff);
                     wr_data = {1'b1, e_size, e_start};
                     idx_in = '0; state_in = S_CRD;
                  end
               end
            end else if (e_free) begin
               if ({1'b0, e_size} == size_ff) begin
                  wr_en = 1'b1; wr_addr = AW'(idx_ff);
                  wr_data = {1'b0, e_size, e_start};
                  addr_in = 16'(18'(e_start) + HDR); state_in = S_DONE;
               end else if ({1'b0, e_size} > size_ff && (!found_ff || e_size < bsize_ff)) begin
                  found_in = 1'b1; best_in = idx_ff; bsize_in = e_size;
               end
            end
         end
         S_PICK: state_in = S_PUSE;
         S_PUSE: begin
            addr_in = 16'(18'(e_start) + HDR);
            wr_en = 1'b1; wr_addr = AW'(best_ff);
            sum = 18'(bsize_ff) - 18'(size_ff);
            if (sum > HDR && count_ff < CW'(MAX_BLOCKS)) begin
               wr_data = {1'b0, size_ff[15:0], e_start};
               ins_in = {1'b1, 16'(sum - HDR),
                         16'(18'(e_start) + HDR + 18'(size_ff))};
               k_in = count_ff; state_in = S_SHRD;
            end else begin
               wr_data = {1'b0, e_size, e_start}; state_in = S_DONE;
            end
         end
         S_SHRD: begin
            if (k_ff == best_ff + 1'b1) begin
               state_in = S_INS;
            end else begin
               rd_addr = AW'(k_ff - 1'b1); state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            wr_en = 1'b1; wr_addr = AW'(k_ff); wr_data = rd_data;
            k_in = k_ff - 1'b1; state_in = S_SHRD;
         end
         S_INS: begin
            wr_en = 1'b1; wr_addr = AW'(k_ff); wr_data = ins_ff;
            count_in = count_ff + 1'b1; state_in = S_DONE;
         end
         S_CRD: begin
            // cur holds entry idx once idx>0; first read loads entry 0
            if (idx_ff + 1'b1 >= count_ff) begin
               state_in = S_DONE;
            end else begin
               rd_addr = AW'(idx_ff + 1'b1); state_in = S_CCHK;
               if (idx_ff == '0 && !found_ff) begin
                  rd_addr = '0;
               end
            end
         end
         S_CCHK: begin
            if (idx_ff == '0 && !found_ff) begin
               cur_in = rd_data; found_in = 1'b1; state_in = S_CRD;
            end else if (cur_ff[32] && e_free) begin
               cur_in = {1'b1, 16'(18'(cur_ff[31:16]) + HDR + 18'(e_size)), cur_ff[15:0]};
               wr_en = 1'b1; wr_addr = AW'(idx_ff);
               wr_data = {1'b1, 16'(18'(cur_ff[31:16]) + HDR + 18'(e_size)), cur_ff[15:0]};
               k_in = idx_ff + 1'b1; state_in = S_RMWR;
               rd_addr = AW'(idx_ff + 2'd2);
            end else begin
               cur_in = rd_data; idx_in = idx_ff + 1'b1; state_in = S_CRD;
            end
         end
         S_RMWR: begin
            // rd_data holds entry k+1
            if (k_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1; state_in = S_CRD;
            end else begin
               wr_en = 1'b1; wr_addr = AW'(k_ff); wr_data = rd_data;
               k_in = k_ff + 1'b1; rd_addr = AW'(k_ff + 2'd2);
            end
         end
         S_DONE: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; top_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; top_ff <= top_in; rv_ff <= rv_in;
      end
      idx_ff <= idx_in; best_ff <= best_in; k_ff <= k_in; op_ff <= op_in;
      size_ff <= size_in; rel_ff <= rel_in; bsize_ff <= bsize_in; found_ff <= found_in;
      cur_ff <= cur_in; ins_ff <= ins_in; addr_ff <= addr_in; st_ff <= st_in;
   end
endmodule

/* rtl/core/bfba_table.sv */
// Block table: one write port, one registered read port.
module bfba_table #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [32:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [32:0]   rd_data
);
   logic [32:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
